[hw/rtl/mmp_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI message parser package
// Shared message kinds, status byte codes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

  // Message kinds as they appear on the msg_kind port.
  typedef enum logic [4:0] {
    KIND_NOTE_OFF   = 5'd0,
    KIND_NOTE_ON    = 5'd1,
    KIND_KEY_PRESS  = 5'd2,
    KIND_CTRL       = 5'd3,
    KIND_PROGRAM    = 5'd4,
    KIND_CHAN_PRESS = 5'd5,
    KIND_BEND       = 5'd6,
    KIND_SONG_POS   = 5'd7,
    KIND_SONG_SEL   = 5'd8,
    KIND_BUS_SEL    = 5'd9,
    KIND_TUNE       = 5'd10,
    KIND_TICK       = 5'd11,
    KIND_START      = 5'd12,
    KIND_CONTINUE   = 5'd13,
    KIND_STOP       = 5'd14,
    KIND_SENSING    = 5'd15,
    KIND_RESET      = 5'd16
  } kind_t;

  // System status bytes.
  localparam logic [7:0] STATUS_SYSEX_START = 8'hF0;
  localparam logic [7:0] STATUS_SONG_POS    = 8'hF2;
  localparam logic [7:0] STATUS_SONG_SEL    = 8'hF3;
  localparam logic [7:0] STATUS_BUS_SEL     = 8'hF5;
  localparam logic [7:0] STATUS_TUNE        = 8'hF6;
  localparam logic [7:0] STATUS_SYSEX_END   = 8'hF7;
  localparam logic [7:0] STATUS_TICK        = 8'hF8;
  localparam logic [7:0] STATUS_START       = 8'hFA;
  localparam logic [7:0] STATUS_CONTINUE    = 8'hFB;
  localparam logic [7:0] STATUS_STOP        = 8'hFC;
  localparam logic [7:0] STATUS_SENSING     = 8'hFE;
  localparam logic [7:0] STATUS_RESET       = 8'hFF;

  // High nibbles of the channel messages.
  localparam logic [3:0] NIB_CHAN_FIRST  = 4'h8;
  localparam logic [3:0] NIB_CHAN_LAST   = 4'hE;
  localparam logic [3:0] NIB_PROGRAM     = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] NIB_SYSTEM      = 4'hF;

  typedef logic [1:0] count_t;

  // One decoded message.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [13:0] wide_value;
  } result_t;

  // What the parse core hands to the output register for one byte.
  typedef struct packed {
    logic    emit;
    result_t result;
  } parse_out_t;

endpackage

`default_nettype wire

[hw/rtl/mmp_decode.sv]
// ----------------------------------------------------------------------------
// MIDI status decoder
// Maps a status byte to its message kind and its count of data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_decode (
  input  wire logic [7:0]     status,
  output mmp_pkg::kind_t      kind,
  output logic                kind_ok,
  output mmp_pkg::count_t     count
);

  always_comb begin
    kind    = mmp_pkg::KIND_NOTE_OFF;
    kind_ok = 1'b0;
    count   = 2'd0;
    if (status[7:4] inside {[mmp_pkg::NIB_CHAN_FIRST:mmp_pkg::NIB_CHAN_LAST]}) begin
      // Channel messages: kind is the high nibble less eight.
      kind    = mmp_pkg::kind_t'({2'b00, status[6:4]});
      kind_ok = 1'b1;
      count   = (status[7:4] inside {mmp_pkg::NIB_PROGRAM, mmp_pkg::NIB_CHAN_PRESS})
                ? 2'd1 : 2'd2;
    end else if (status[7:4] == mmp_pkg::NIB_SYSTEM) begin
      kind_ok = 1'b1;
      case (status)
        mmp_pkg::STATUS_SONG_POS: begin
          kind  = mmp_pkg::KIND_SONG_POS;
          count = 2'd2;
        end
        mmp_pkg::STATUS_SONG_SEL: begin
          kind  = mmp_pkg::KIND_SONG_SEL;
          count = 2'd1;
        end
        mmp_pkg::STATUS_BUS_SEL: begin
          kind  = mmp_pkg::KIND_BUS_SEL;
          count = 2'd1;
        end
        mmp_pkg::STATUS_TUNE:     kind = mmp_pkg::KIND_TUNE;
        mmp_pkg::STATUS_TICK:     kind = mmp_pkg::KIND_TICK;
        mmp_pkg::STATUS_START:    kind = mmp_pkg::KIND_START;
        mmp_pkg::STATUS_CONTINUE: kind = mmp_pkg::KIND_CONTINUE;
        mmp_pkg::STATUS_STOP:     kind = mmp_pkg::KIND_STOP;
        mmp_pkg::STATUS_SENSING:  kind = mmp_pkg::KIND_SENSING;
        mmp_pkg::STATUS_RESET:    kind = mmp_pkg::KIND_RESET;
        default:                  kind_ok = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mmp_parse.sv]
// ----------------------------------------------------------------------------
// MIDI parse core
// Holds the message state and decodes one byte per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                enable,
  input  wire logic [7:0]          rx_byte,
  output mmp_pkg::parse_out_t      parse_out
);

  logic [7:0]      held_status;
  logic [7:0]      held_status_next;
  mmp_pkg::count_t bytes_remaining;
  mmp_pkg::count_t bytes_remaining_next;
  logic [7:0]      saved_first_data;
  logic [7:0]      saved_first_data_next;
  logic            in_sysex;
  logic            in_sysex_next;

  mmp_pkg::kind_t  held_kind;
  logic            held_kind_ok;
  mmp_pkg::count_t held_count;
  mmp_pkg::kind_t  new_kind;
  logic            new_kind_ok;
  mmp_pkg::count_t new_count;

  logic [7:0]      d1;
  logic [7:0]      d2;

  mmp_decode u_held_decode (
    .status  (held_status),
    .kind    (held_kind),
    .kind_ok (held_kind_ok),
    .count   (held_count)
  );

  mmp_decode u_new_decode (
    .status  (rx_byte),
    .kind    (new_kind),
    .kind_ok (new_kind_ok),
    .count   (new_count)
  );

  always_comb begin
    held_status_next      = held_status;
    bytes_remaining_next  = bytes_remaining;
    saved_first_data_next = saved_first_data;
    in_sysex_next         = in_sysex;
    parse_out             = '0;
    d1                    = 8'd0;
    d2                    = 8'd0;

    if (in_sysex) begin
      if (rx_byte == mmp_pkg::STATUS_SYSEX_END) begin
        in_sysex_next = 1'b0;
      end
    end else if (bytes_remaining != 2'd0) begin
      if (held_count == 2'd2 && bytes_remaining == 2'd2) begin
        saved_first_data_next = rx_byte;
        bytes_remaining_next  = 2'd1;
      end else begin
        bytes_remaining_next = 2'd0;
        if (held_count == 2'd2) begin
          d1 = saved_first_data;
          d2 = rx_byte;
        end else begin
          d1 = rx_byte;
        end
        parse_out.emit        = held_kind_ok;
        parse_out.result.kind = held_kind;
      end
      parse_out.result.channel = held_status[3:0];
    end else if (rx_byte[7]) begin
      held_status_next      = rx_byte;
      saved_first_data_next = 8'd0;
      if (rx_byte == mmp_pkg::STATUS_SYSEX_START) begin
        in_sysex_next = 1'b1;
      end else begin
        bytes_remaining_next = new_count;
        parse_out.emit       = new_kind_ok && (new_count == 2'd0);
      end
      parse_out.result.kind    = new_kind;
      parse_out.result.channel = rx_byte[3:0];
    end

    parse_out.result.first_data  = d1;
    parse_out.result.second_data = d2;
    parse_out.result.wide_value  = {d2[6:0], d1[6:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_status      <= 8'd0;
      bytes_remaining  <= 2'd0;
      saved_first_data <= 8'd0;
      in_sysex         <= 1'b0;
    end else if (enable) begin
      held_status      <= held_status_next;
      bytes_remaining  <= bytes_remaining_next;
      saved_first_data <= saved_first_data_next;
      in_sysex         <= in_sysex_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/midi_message_parser.sv]
// ----------------------------------------------------------------------------
// MIDI message parser
// Turns a stream of received MIDI bytes into decoded messages.
// ----------------------------------------------------------------------------
// An accepted word is held in the input register, decoded by the parse core
// and its message loaded into the result register, where the receiver takes it.
// Throughput: one word per cycle unless stalled; the pipeline is an input
// register, the parse core state and a result register, advancing together.
// Reset: rst (synchronous) empties both registers and clears the parser
// state, so no message is pending and no system exclusive block is open.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel: one received byte per word.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // Output channel: one decoded message per word.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       msg_kind,
  output logic [3:0]       channel,
  output logic [7:0]       first_data,
  output logic [7:0]       second_data,
  output logic [13:0]      wide_value
);

  // Input register. It holds the byte that the parse core works on.
  logic       byte_valid;
  logic [7:0] byte_q;

  // Result register.
  mmp_pkg::result_t result_q;

  mmp_pkg::parse_out_t parse_out;

  logic in_accept;
  logic advance;
  logic step;

  // The parse stage may move whenever the result register is empty or its
  // word is being taken this cycle. Every byte waits for that, even one that
  // yields no result, which keeps the state update in order with the output.
  assign advance   = !out_valid || !out_stall;
  assign step      = byte_valid && advance;
  assign in_stall  = byte_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  mmp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .enable    (step),
    .rx_byte   (byte_q),
    .parse_out (parse_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_accept) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_q <= rx_byte;
    end
  end

  // The result register loads when the parse core emits a message and
  // empties when its word is taken without a new one behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && parse_out.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && parse_out.emit) begin
      result_q <= parse_out.result;
    end
  end

  assign msg_kind    = result_q.kind;
  assign channel     = result_q.channel;
  assign first_data  = result_q.first_data;
  assign second_data = result_q.second_data;
  assign wide_value  = result_q.wide_value;

endmodule

`default_nettype wire
